// ===== src/gtpm_pkg.sv =====
`default_nettype none
package gtpm_pkg;
  localparam int MAX_SEQS_DEF = 32;
  localparam int SIM_BITS_DEF = 16;
  localparam int IDX_W = 5;
  localparam int CFG_W = 6;
  localparam int NUM_SEQS_RST = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT,
    ST_UPD_RD_A,
    ST_UPD_RD_B,
    ST_UPD_MUL,
    ST_UPD_WR_A,
    ST_UPD_WR_B
  } state_t;
endpackage
`default_nettype wire

// ===== src/gtpm_if.sv =====
`default_nettype none
interface gtpm_in_if #(parameter int IW = 5, parameter int SW = 16);
  logic valid;
  logic ready;
  logic [IW-1:0] row;
  logic [IW-1:0] col;
  logic [SW-1:0] sim;
  logic load_done;
  modport source (output valid, row, col, sim, load_done, input ready);
  modport sink (input valid, row, col, sim, load_done, output ready);
endinterface

interface gtpm_out_if #(parameter int IW = 5, parameter int SW = 16);
  logic valid;
  logic ready;
  logic [IW-1:0] left_cluster;
  logic [IW-1:0] right_cluster;
  logic [SW-1:0] merge_sim;
  logic final_merge;
  modport source (output valid, left_cluster, right_cluster, merge_sim, final_merge,
                  input ready);
  modport sink (input valid, left_cluster, right_cluster, merge_sim, final_merge,
                output ready);
endinterface
`default_nettype wire

// ===== src/guide_tree_pair_merge.sv =====
// load: one word stored per cycle (out-of-range row/col not stored); load_done with n > 1 starts a scan
// merge round with m of n clusters active: scan visits every pair (read and compare per
// active pair, read only per skipped pair), emit holds until ready, update steps each k
// through the single store port (read, read, multiply, write, write per active k)
// reset (rst_n low, synchronous) clears control, sets all active flags and num_seqs=32;
// the store contents are undefined until written
`default_nettype none
module guide_tree_pair_merge
  import gtpm_pkg::*;
#(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int SIM_BITS = SIM_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic [CFG_W-1:0] cfg_wdata,
  gtpm_in_if.sink in_ch,
  gtpm_out_if.source out_ch
);
  localparam int DEPTH = MAX_SEQS * MAX_SEQS;
  localparam int AW = $clog2(DEPTH);
  localparam int KW = $clog2(MAX_SEQS + 1);

  // single-port store, registered read
  logic [SIM_BITS-1:0] mem [DEPTH];
  logic [SIM_BITS-1:0] rdata_r;
  logic [AW-1:0] addr;
  logic we;
  logic [SIM_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  state_t st_r, st_nxt;
  logic [CFG_W-1:0] nseq_r;
  logic [KW-1:0] n_r, n_nxt;
  logic [MAX_SEQS-1:0] act_r, act_nxt;
  logic [KW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [KW-1:0] bi_r, bi_nxt, bj_r, bj_nxt;
  logic [SIM_BITS-1:0] best_r, best_nxt, a_r, a_nxt;
  logic found_r, found_nxt;
  logic [KW-1:0] left_r, left_nxt;
  logic [2*SIM_BITS+1:0] prod_r, prod_nxt;

  function automatic logic [AW-1:0] ad(input logic [KW-1:0] r, input logic [KW-1:0] c);
    logic [2*KW-1:0] t;
    t = r * MAX_SEQS[KW-1:0] + {{KW{1'b0}}, c};
    return t[AW-1:0];
  endfunction

  logic [CFG_W-1:0] nclip;
  assign nclip = (int'(nseq_r) > MAX_SEQS) ? CFG_W'(MAX_SEQS) : nseq_r;

  assign in_ch.ready = (st_r == ST_LOAD);
  assign out_ch.valid = (st_r == ST_EMIT);
  assign out_ch.left_cluster = IDX_W'(bi_r);
  assign out_ch.right_cluster = IDX_W'(bj_r);
  assign out_ch.merge_sim = best_r;
  assign out_ch.final_merge = (left_r == KW'(1));

  // scan stepping: next j, then next i (inactive pairs are skipped in ST_SCAN_RD)
  logic [KW-1:0] jn, in_s;
  logic scan_end, pair_ok;
  always_comb begin
    pair_ok = act_r[i_r[$clog2(MAX_SEQS)-1:0]] && act_r[j_r[$clog2(MAX_SEQS)-1:0]];
    jn = j_r + 1'b1;
    in_s = i_r;
    scan_end = 1'b0;
    if (jn >= n_r) begin
      in_s = i_r + 1'b1;
      jn = i_r + KW'(2);
      if (jn >= n_r) scan_end = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; act_nxt = act_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; bi_nxt = bi_r; bj_nxt = bj_r;
    best_nxt = best_r; a_nxt = a_r; found_nxt = found_r; left_nxt = left_r;
    prod_nxt = prod_r;
    we = 1'b0; addr = ad(i_r, j_r); wdata = in_ch.sim;
    case (st_r)
      ST_LOAD: begin
        addr = ad(KW'(in_ch.row), KW'(in_ch.col));
        if (in_ch.valid) begin
          we = (int'(in_ch.row) < MAX_SEQS) && (int'(in_ch.col) < MAX_SEQS);
          if (in_ch.load_done) begin
            act_nxt = '1;
            n_nxt = KW'(nclip);
            left_nxt = (nclip > 1) ? KW'(nclip - 1'b1) : '0;
            i_nxt = '0; j_nxt = KW'(1); found_nxt = 1'b0;
            if (nclip > 1) st_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (pair_ok) st_nxt = ST_SCAN_CMP;
        else if (scan_end) st_nxt = found_r ? ST_EMIT : ST_LOAD;
        else begin i_nxt = in_s; j_nxt = jn; end
      end
      ST_SCAN_CMP: begin
        if (!found_r || rdata_r > best_r) begin
          found_nxt = 1'b1; best_nxt = rdata_r; bi_nxt = i_r; bj_nxt = j_r;
        end
        if (scan_end) st_nxt = ST_EMIT;
        else begin i_nxt = in_s; j_nxt = jn; st_nxt = ST_SCAN_RD; end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          left_nxt = left_r - 1'b1; k_nxt = '0; st_nxt = ST_UPD_RD_A;
        end
      end
      ST_UPD_RD_A: begin
        addr = ad(k_r, bi_r);
        if (k_r >= n_r) begin
          act_nxt[bj_r[$clog2(MAX_SEQS)-1:0]] = 1'b0;
          i_nxt = '0; j_nxt = KW'(1); found_nxt = 1'b0;
          st_nxt = (left_r == '0) ? ST_LOAD : ST_SCAN_RD;
        end else if (!act_r[k_r[$clog2(MAX_SEQS)-1:0]]) k_nxt = k_r + 1'b1;
        else st_nxt = ST_UPD_RD_B;
      end
      ST_UPD_RD_B: begin
        addr = ad(k_r, bj_r); a_nxt = rdata_r; st_nxt = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        prod_nxt = ({1'b0, a_r} + {1'b0, rdata_r}) * best_r;
        st_nxt = ST_UPD_WR_A;
      end
      ST_UPD_WR_A: begin
        addr = ad(bi_r, k_r); we = 1'b1;
        wdata = prod_r[2*SIM_BITS:SIM_BITS+1]; st_nxt = ST_UPD_WR_B;
      end
      ST_UPD_WR_B: begin
        addr = ad(k_r, bi_r); we = 1'b1;
        wdata = prod_r[2*SIM_BITS:SIM_BITS+1];
        k_nxt = k_r + 1'b1; st_nxt = ST_UPD_RD_A;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; nseq_r <= CFG_W'(NUM_SEQS_RST); act_r <= '1; left_r <= '0;
      found_r <= 1'b0; n_r <= '0;
    end else begin
      st_r <= st_nxt; act_r <= act_nxt; left_r <= left_nxt; found_r <= found_nxt;
      n_r <= n_nxt;
      if (cfg_we) nseq_r <= cfg_wdata;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; bi_r <= bi_nxt; bj_r <= bj_nxt;
    best_r <= best_nxt; a_r <= a_nxt; prod_r <= prod_nxt;
  end

  a_emit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> bi_r < bj_r) else $error("merge pair order");
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("load during merge");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(best_r))
    else $error("result dropped");
endmodule
`default_nettype wire
